@@ rtl/glmf_pkg.sv @@
// Shared types, constants and helpers for the grid local maximum finder.
package glmf_pkg;

	localparam int MAX_WIDTH     = 64;
	localparam int MAX_HEIGHT    = 64;
	localparam int VALUE_BITS    = 16;
	localparam int COORD_BITS    = 6;
	localparam int SIZE_BITS     = 7;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 7;
	localparam int HIT_BITS      = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Bits of a peak set, in the order they are reported
	localparam int HIT_UP_ROW = 0;  // cell one row above the arriving one
	localparam int HIT_LEFT   = 1;  // last row: cell left of the arriving one
	localparam int HIT_SELF   = 2;  // last row, last column: the arriving cell

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic [SIZE_BITS-1:0]         size_t;

	// Fixed taps of one line delay: the exiting value and the one behind it
	typedef struct packed {
		value_t tap0;
		value_t tap1;
	} line_taps_t;

	// Peaks found for one pixel, with the position of that pixel
	typedef struct packed {
		logic [HIT_BITS-1:0] hit;
		coord_t              row;
		coord_t              col;
	} peak_set_t;

	// Zero is taken as one, anything above the maximum as the maximum
	function automatic size_t clamp_size(input logic [CFG_DATA_BITS-1:0] v,
		input size_t max_v);
		size_t r;
		r = SIZE_BITS'(v);
		if (r == '0) begin
			r = SIZE_BITS'(1);
		end else if (r > max_v) begin
			r = max_v;
		end
		return r;
	endfunction

endpackage

@@ rtl/glmf_cell.sv @@
// One storage cell of a line delay chain.
module glmf_cell (
	input  logic               clk,
	input  logic               shift_en,
	input  logic               is_end,
	input  glmf_pkg::value_t   d_next,
	input  glmf_pkg::value_t   d_in,
	output glmf_pkg::value_t   q
);

	glmf_pkg::value_t val_q;

	// Tail cell takes the new value, all others take their upstream neighbor
	always_ff @(posedge clk) begin
		if (shift_en) begin
			val_q <= is_end ? d_in : d_next;
		end
	end

	assign q = val_q;

endmodule

@@ rtl/glmf_line.sv @@
// Variable-length line delay built from a chain of cells.
module glmf_line (
	input  logic                  clk,
	input  logic                  shift_en,
	input  glmf_pkg::coord_t      end_idx,
	input  glmf_pkg::value_t      d_in,
	output glmf_pkg::line_taps_t  taps
);

	glmf_pkg::value_t cell_val [glmf_pkg::MAX_WIDTH];

	// Data enters at cell end_idx and walks toward cell 0: delay of end_idx+1 shifts
	for (genvar k = 0; k < glmf_pkg::MAX_WIDTH; k++) begin : g_cell
		glmf_pkg::value_t nb;
		if (k == glmf_pkg::MAX_WIDTH - 1) begin : g_tail
			assign nb = d_in;
		end else begin : g_mid
			assign nb = cell_val[k+1];
		end
		glmf_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.is_end   (glmf_pkg::COORD_BITS'(k) == end_idx),
			.d_next   (nb),
			.d_in     (d_in),
			.q        (cell_val[k])
		);
	end

	assign taps.tap0 = cell_val[0];
	assign taps.tap1 = cell_val[1];

endmodule

@@ rtl/glmf_emit.sv @@
// Result register: holds the peaks of one pixel and hands them out one per cycle while the receiver does not stall.
module glmf_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  glmf_pkg::peak_set_t   set_in,
	output logic                  can_load,
	output logic                  out_valid,
	input  logic                  out_stall,
	output glmf_pkg::coord_t      peak_row,
	output glmf_pkg::coord_t      peak_column,
	output logic                  last_of_run
);

	logic [glmf_pkg::HIT_BITS-1:0] hit_q;
	glmf_pkg::coord_t              row_q;
	glmf_pkg::coord_t              col_q;
	logic [glmf_pkg::HIT_BITS-1:0] sel;
	logic [glmf_pkg::HIT_BITS-1:0] hit_rest;
	logic                          pop;

	// Lowest pending peak goes first
	assign sel       = hit_q & (~hit_q + glmf_pkg::HIT_BITS'(1));
	assign out_valid = |hit_q;
	assign last_of_run = (hit_q & ~sel) == '0;
	assign pop       = out_valid && !out_stall;
	assign hit_rest  = pop ? (hit_q & ~sel) : hit_q;
	assign can_load  = hit_rest == '0;

	assign peak_row    = sel[glmf_pkg::HIT_UP_ROW] ? row_q - glmf_pkg::COORD_BITS'(1) : row_q;
	assign peak_column = sel[glmf_pkg::HIT_LEFT] ? col_q - glmf_pkg::COORD_BITS'(1) : col_q;

	// Pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (load) begin
			hit_q <= set_in.hit;
		end else begin
			hit_q <= hit_rest;
		end
	end

	// Pixel position of the pending set
	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= set_in.row;
			col_q <= set_in.col;
		end
	end

endmodule

@@ rtl/grid_local_maximum_finder.sv @@
// Top level of the grid local maximum finder.
//
// Pixels arrive in raster order on the in_valid/in_stall channel (pixel_value,
// signed). Each transaction may release up to three peaks, reported on the
// out_valid/out_stall channel as peak_row/peak_column; last_of_run marks the
// final peak released by one pixel. A pixel that releases nothing gives no
// output transaction.
// Latency: peaks of a pixel show on the outputs the cycle after it is taken.
// Throughput: one pixel per cycle while each pixel releases at most one peak
// and the receiver does not stall; a pixel releasing more peaks holds the
// input until its last peak is taken, since the single result register drains
// one peak per cycle. Only last-row pixels release more than one.
// Two line delays, each a chain of MAX_WIDTH cells, hold the two rows above.
// Configuration (image_width, image_height) goes through cfg_valid/cfg_ready,
// always ready; a write to either size register restarts the frame at row 0,
// column 0. Write it only while the block is idle.
// Reset empties the result register and sets both sizes to their maximum.
// While the receiver stalls, the current peak holds and in_stall rises once
// the pending peaks cannot make room for the next pixel.
module grid_local_maximum_finder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  glmf_pkg::value_t                      pixel_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output glmf_pkg::coord_t                      peak_row,
	output glmf_pkg::coord_t                      peak_column,
	output logic                                  last_of_run,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [glmf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [glmf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	logic [glmf_pkg::CFG_DATA_BITS-1:0] width_q;
	logic [glmf_pkg::CFG_DATA_BITS-1:0] height_q;
	glmf_pkg::coord_t                   row_q;
	glmf_pkg::coord_t                   col_q;
	glmf_pkg::value_t                   prev_up_q;
	glmf_pkg::value_t                   prev_pix_q;
	glmf_pkg::value_t                   prev2_pix_q;

	glmf_pkg::size_t      w_eff;
	glmf_pkg::size_t      h_eff;
	glmf_pkg::coord_t     r_cur;
	glmf_pkg::coord_t     c_cur;
	glmf_pkg::coord_t     end_idx;
	glmf_pkg::line_taps_t up_taps;
	glmf_pkg::line_taps_t up2_taps;
	glmf_pkg::peak_set_t  set_in;
	logic                 accept;
	logic                 can_load;
	logic                 cfg_hit;
	logic                 r_gt0, r_gt1, c_gt0, c_gt1;
	logic                 last_row, last_col;
	glmf_pkg::value_t     x, a0, a1, b0;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == glmf_pkg::REG_IMAGE_WIDTH ||
		cfg_index == glmf_pkg::REG_IMAGE_HEIGHT);

	assign w_eff = glmf_pkg::clamp_size(width_q, glmf_pkg::SIZE_BITS'(glmf_pkg::MAX_WIDTH));
	assign h_eff = glmf_pkg::clamp_size(height_q, glmf_pkg::SIZE_BITS'(glmf_pkg::MAX_HEIGHT));
	assign end_idx = glmf_pkg::COORD_BITS'(w_eff - glmf_pkg::SIZE_BITS'(1));

	assign in_stall = !can_load;
	assign accept   = in_valid && can_load;

	// Position of the arriving pixel, restarted if outside the grid
	always_comb begin
		r_cur = row_q;
		c_cur = col_q;
		if (glmf_pkg::SIZE_BITS'(row_q) >= h_eff || glmf_pkg::SIZE_BITS'(col_q) >= w_eff) begin
			r_cur = '0;
			c_cur = '0;
		end
	end

	// Two stacked line delays: row above and two rows above
	glmf_line u_line_up (
		.clk      (clk),
		.shift_en (accept),
		.end_idx  (end_idx),
		.d_in     (pixel_value),
		.taps     (up_taps)
	);

	glmf_line u_line_up2 (
		.clk      (clk),
		.shift_en (accept),
		.end_idx  (end_idx),
		.d_in     (up_taps.tap0),
		.taps     (up2_taps)
	);

	// Neighborhood compare for the three candidate cells
	always_comb begin
		x        = pixel_value;
		a0       = up_taps.tap0;
		a1       = up_taps.tap1;
		b0       = up2_taps.tap0;
		r_gt0    = r_cur != '0;
		r_gt1    = r_cur > glmf_pkg::COORD_BITS'(1);
		c_gt0    = c_cur != '0;
		c_gt1    = c_cur > glmf_pkg::COORD_BITS'(1);
		last_row = glmf_pkg::SIZE_BITS'(r_cur) + glmf_pkg::SIZE_BITS'(1) == h_eff;
		last_col = glmf_pkg::SIZE_BITS'(c_cur) + glmf_pkg::SIZE_BITS'(1) == w_eff;

		set_in.row = r_cur;
		set_in.col = c_cur;
		// cell above the arriving pixel; its lower neighbor is the pixel itself
		set_in.hit[glmf_pkg::HIT_UP_ROW] = r_gt0 && !((r_gt1 && b0 > a0) || (x > a0) ||
			(c_gt0 && prev_up_q > a0) || (!last_col && a1 > a0));
		// last row: cell left of the arriving pixel
		set_in.hit[glmf_pkg::HIT_LEFT] = last_row && c_gt0 && !((r_gt0 && prev_up_q > prev_pix_q) ||
			(c_gt1 && prev2_pix_q > prev_pix_q) || (x > prev_pix_q));
		// last cell of the grid
		set_in.hit[glmf_pkg::HIT_SELF] = last_row && last_col &&
			!((r_gt0 && a0 > x) || (c_gt0 && prev_pix_q > x));
	end

	glmf_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.set_in      (set_in),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.peak_row    (peak_row),
		.peak_column (peak_column),
		.last_of_run (last_of_run)
	);

	// Configuration registers and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= glmf_pkg::CFG_DATA_BITS'(glmf_pkg::MAX_WIDTH);
			height_q <= glmf_pkg::CFG_DATA_BITS'(glmf_pkg::MAX_HEIGHT);
			row_q    <= '0;
			col_q    <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == glmf_pkg::REG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r_cur + glmf_pkg::COORD_BITS'(1);
			end else begin
				col_q <= c_cur + glmf_pkg::COORD_BITS'(1);
				row_q <= r_cur;
			end
		end
	end

	// Recent values for left and upper-left neighbors
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_up_q   <= a0;
			prev_pix_q  <= x;
			prev2_pix_q <= prev_pix_q;
		end
	end

endmodule

@@ rtl/glmf_checker.sv @@
// Port-level checks for the grid local maximum finder, bound to the top level.
module glmf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input glmf_pkg::coord_t                    peak_row,
	input glmf_pkg::coord_t                    peak_column,
	input logic                                last_of_run
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(peak_row) && $stable(peak_column) &&
		$stable(last_of_run))
		else $error("stalled result changed");

	// Nothing pending means the input is open
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with no pending result");

	// A run not yet at its last peak continues
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("run of peaks cut short");

endmodule

bind grid_local_maximum_finder glmf_checker u_glmf_checker (.*);

@@ bench/grid_local_maximum_finder_tb.sv @@
// Self-checking testbench for the grid local maximum finder: directed grids, then random frames.
`timescale 1ns / 1ps

module grid_local_maximum_finder_tb;

	localparam int          RANDOM_PIXELS = 350;
	localparam int unsigned MAX_FRAME     = 200;   // cells per random frame at most
	localparam int          DRAIN_CYCLES  = 4;     // quiet cycles before a register write
	localparam int          QUIET_LIMIT   = 2000;  // watchdog: cycles with no transaction

	// Indexes outside the register map, used to check that such writes are dropped
	localparam logic [glmf_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [glmf_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_3 = 2'd3;

	typedef enum int {FULL_RANGE, FEW_LEVELS, EXTREMES, NEAR_ZERO} pixel_mix_t;

	typedef struct {
		glmf_pkg::coord_t row;
		glmf_pkg::coord_t col;
		logic             last;
	} peak_t;

	// Tracks the grid position and the three rows in use, and queues the peaks due
	class peak_scoreboard;
		glmf_pkg::value_t                   line_store[3*glmf_pkg::MAX_WIDTH];
		logic [glmf_pkg::CFG_DATA_BITS-1:0] width_reg;
		logic [glmf_pkg::CFG_DATA_BITS-1:0] height_reg;
		int unsigned                        row_pos;
		int unsigned                        col_pos;
		peak_t                              expected_peaks[$];
		int unsigned                        errors;
		int unsigned                        pixels;
		int unsigned                        peaks;
		int unsigned                        writes;

		function new();
			foreach (line_store[i]) begin
				line_store[i] = '0;
			end
			width_reg  = glmf_pkg::CFG_DATA_BITS'(glmf_pkg::MAX_WIDTH);
			height_reg = glmf_pkg::CFG_DATA_BITS'(glmf_pkg::MAX_HEIGHT);
			row_pos    = 0;
			col_pos    = 0;
			errors     = 0;
			pixels     = 0;
			peaks      = 0;
			writes     = 0;
		endfunction

		// Zero counts as one, oversize as the maximum
		function int unsigned span(input logic [glmf_pkg::CFG_DATA_BITS-1:0] raw,
			input int unsigned limit);
			if (raw == 0) begin
				return 1;
			end
			if (raw > limit) begin
				return limit;
			end
			return int'(raw);
		endfunction

		function glmf_pkg::value_t stored(input int unsigned r, input int unsigned c);
			return line_store[(r % 3) * glmf_pkg::MAX_WIDTH + (c % glmf_pkg::MAX_WIDTH)];
		endfunction

		// Neighbors outside the grid do not count
		function bit is_local_max(input int unsigned r, c, w, h);
			glmf_pkg::value_t v;
			v = stored(r, c);
			if (r > 0 && stored(r - 1, c) > v) return 1'b0;
			if (r + 1 < h && stored(r + 1, c) > v) return 1'b0;
			if (c > 0 && stored(r, c - 1) > v) return 1'b0;
			if (c + 1 < w && stored(r, c + 1) > v) return 1'b0;
			return 1'b1;
		endfunction

		// Size writes restart the frame; unknown indexes change nothing
		function void apply_write(input logic [glmf_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [glmf_pkg::CFG_DATA_BITS-1:0] data);
			writes++;
			if (idx == glmf_pkg::REG_IMAGE_WIDTH) begin
				width_reg = data;
			end else if (idx == glmf_pkg::REG_IMAGE_HEIGHT) begin
				height_reg = data;
			end else begin
				return;
			end
			row_pos = 0;
			col_pos = 0;
		endfunction

		function void note_pixel(input glmf_pkg::value_t v);
			int unsigned w;
			int unsigned h;
			int unsigned r;
			int unsigned c;
			peak_t       found[$];
			peak_t       p;
			w = span(width_reg, glmf_pkg::MAX_WIDTH);
			h = span(height_reg, glmf_pkg::MAX_HEIGHT);
			r = row_pos;
			c = col_pos;
			if (r >= h || c >= w) begin
				r = 0;
				c = 0;
			end
			line_store[(r % 3) * glmf_pkg::MAX_WIDTH + c] = v;
			p.last = 1'b0;
			// Cell above is complete once its lower neighbor is in
			if (r > 0 && is_local_max(r - 1, c, w, h)) begin
				p.row = glmf_pkg::coord_t'(r - 1);
				p.col = glmf_pkg::coord_t'(c);
				found.push_back(p);
			end
			// Last row: left cell now has its right neighbor; last cell decides itself
			if (r + 1 == h) begin
				if (c > 0 && is_local_max(r, c - 1, w, h)) begin
					p.row = glmf_pkg::coord_t'(r);
					p.col = glmf_pkg::coord_t'(c - 1);
					found.push_back(p);
				end
				if (c + 1 == w && is_local_max(r, c, w, h)) begin
					p.row = glmf_pkg::coord_t'(r);
					p.col = glmf_pkg::coord_t'(c);
					found.push_back(p);
				end
			end
			foreach (found[i]) begin
				p      = found[i];
				p.last = (i == found.size() - 1);
				expected_peaks.push_back(p);
			end
			pixels++;
			peaks += found.size();
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h) begin
					r = 0;
				end
			end
			row_pos = r;
			col_pos = c;
		endfunction

		function void check_peak(input glmf_pkg::coord_t r, input glmf_pkg::coord_t c,
			input logic last);
			peak_t want;
			if (expected_peaks.size() == 0) begin
				$error("unexpected peak: row %0d column %0d last_of_run %0b", r, c, last);
				errors++;
				return;
			end
			want = expected_peaks.pop_front();
			if (want.row !== r) begin
				$error("peak_row: expected %0d, actual %0d", want.row, r);
				errors++;
			end
			if (want.col !== c) begin
				$error("peak_column: expected %0d, actual %0d", want.col, c);
				errors++;
			end
			if (want.last !== last) begin
				$error("last_of_run: expected %0b, actual %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                               clk         = 1'b0;
	logic                               arst_n      = 1'b0;
	logic                               in_valid    = 1'b0;
	logic                               in_stall;
	glmf_pkg::value_t                   pixel_value = '0;
	logic                               out_valid;
	logic                               out_stall   = 1'b0;
	glmf_pkg::coord_t                   peak_row;
	glmf_pkg::coord_t                   peak_column;
	logic                               last_of_run;
	logic                               cfg_valid   = 1'b0;
	logic                               cfg_ready;
	logic [glmf_pkg::CFG_IDX_BITS-1:0]  cfg_index   = '0;
	logic [glmf_pkg::CFG_DATA_BITS-1:0] cfg_data    = '0;

	bit             calm         = 1'b0;  // no idling on either side while set
	int             quiet_cycles = 0;
	peak_scoreboard sb           = new();

	grid_local_maximum_finder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.peak_row    (peak_row),
		.peak_column (peak_column),
		.last_of_run (last_of_run),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Transaction monitor for all three channels, plus the idle count
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_pixel(pixel_value);
			end
			if (out_valid && !out_stall) begin
				sb.check_peak(peak_row, peak_column, last_of_run);
			end
			if (cfg_valid && cfg_ready) begin
				sb.apply_write(cfg_index, cfg_data);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Watchdog
	initial begin
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("Mismatches found");
		$finish;
	end

	// Receiver: random stall before each peak
	initial begin
		int unsigned gap;
		forever begin
			gap = calm ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_pixel(input glmf_pkg::value_t v);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid, let the monitor see the last pixel, wait for every due peak
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_peaks.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(input logic [glmf_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [glmf_pkg::CFG_DATA_BITS-1:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [glmf_pkg::CFG_DATA_BITS-1:0] draw_size();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) return glmf_pkg::CFG_DATA_BITS'($urandom_range(1, 8));
		if (pick == 6) return '0;
		if (pick == 7) return glmf_pkg::CFG_DATA_BITS'($urandom_range(64, 127));
		return glmf_pkg::CFG_DATA_BITS'($urandom_range(9, 63));
	endfunction

	function automatic glmf_pkg::value_t draw_pixel(input pixel_mix_t mix);
		case (mix)
			FULL_RANGE: begin
				return glmf_pkg::value_t'($urandom);
			end
			FEW_LEVELS: begin
				return glmf_pkg::value_t'($urandom_range(0, 3));
			end
			EXTREMES: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default: begin
				return glmf_pkg::value_t'(int'($urandom_range(0, 8)) - 4);
			end
		endcase
	endfunction

	initial begin
		int unsigned random_pixels;
		int unsigned phases;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes (64x64): first row only, nothing decided yet
		send_pixel(16'sh7FFF);
		send_pixel(16'sh8000);
		send_pixel(16'sh0000);

		// Single cell grid, written mid-frame
		set_register(glmf_pkg::REG_IMAGE_WIDTH, 7'd1);
		set_register(glmf_pkg::REG_IMAGE_HEIGHT, 7'd1);
		send_pixel(16'sh8000);
		send_pixel(16'sh7FFF);

		// Zero sizes behave as one
		set_register(glmf_pkg::REG_IMAGE_WIDTH, 7'd0);
		set_register(glmf_pkg::REG_IMAGE_HEIGHT, 7'd0);
		send_pixel(16'sh5A5A);

		// Writes to unmapped indexes are dropped
		set_register(REG_UNUSED_2, 7'h7F);
		set_register(REG_UNUSED_3, 7'h00);

		// 3x2 with extremes and a tie on the last row
		set_register(glmf_pkg::REG_IMAGE_WIDTH, 7'd3);
		set_register(glmf_pkg::REG_IMAGE_HEIGHT, 7'd2);
		send_pixel(16'sh0000);
		send_pixel(16'sh7FFF);
		send_pixel(16'sh0000);
		send_pixel(16'sh8000);
		send_pixel(16'sh0005);
		send_pixel(16'sh0005);

		// Single column with a tie
		set_register(glmf_pkg::REG_IMAGE_WIDTH, 7'd1);
		set_register(glmf_pkg::REG_IMAGE_HEIGHT, 7'd3);
		send_pixel(16'sh0001);
		send_pixel(16'sh0007);
		send_pixel(16'sh0007);

		// Flat 2x2: every cell is a peak, the last pixel releases three
		set_register(glmf_pkg::REG_IMAGE_WIDTH, 7'd2);
		set_register(glmf_pkg::REG_IMAGE_HEIGHT, 7'd2);
		repeat (4) send_pixel(16'shFFFF);

		// Oversized width clamps to the maximum; single row
		set_register(glmf_pkg::REG_IMAGE_WIDTH, 7'd127);
		set_register(glmf_pkg::REG_IMAGE_HEIGHT, 7'd1);
		send_pixel(16'sh0003);
		send_pixel(16'sh0009);
		send_pixel(16'sh0002);

		// Random frames, each with its own sizes and mix of values
		random_pixels = 0;
		phases        = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			logic [glmf_pkg::CFG_DATA_BITS-1:0] w_raw;
			logic [glmf_pkg::CFG_DATA_BITS-1:0] h_raw;
			int unsigned                        w_eff;
			int unsigned                        h_eff;
			int unsigned                        frame;
			int unsigned                        count;
			int unsigned                        split;
			pixel_mix_t                         mix;
			if (phases == 0) begin
				w_raw = 7'd1;
				h_raw = 7'd127;
			end else if (phases == 1) begin
				w_raw = 7'd64;
				h_raw = 7'd2;
			end else begin
				w_raw = draw_size();
				h_raw = draw_size();
			end
			w_eff = sb.span(w_raw, glmf_pkg::MAX_WIDTH);
			h_eff = sb.span(h_raw, glmf_pkg::MAX_HEIGHT);
			// Keep frames short by trimming the smaller side
			if (w_eff * h_eff > MAX_FRAME) begin
				if (w_eff >= h_eff) begin
					h_eff = MAX_FRAME / w_eff;
					h_raw = glmf_pkg::CFG_DATA_BITS'(h_eff);
				end else begin
					w_eff = MAX_FRAME / h_eff;
					w_raw = glmf_pkg::CFG_DATA_BITS'(w_eff);
				end
			end
			frame = w_eff * h_eff;
			calm  = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 0) begin
				set_register(glmf_pkg::REG_IMAGE_WIDTH, w_raw);
				set_register(glmf_pkg::REG_IMAGE_HEIGHT, h_raw);
			end else begin
				set_register(glmf_pkg::REG_IMAGE_HEIGHT, h_raw);
				set_register(glmf_pkg::REG_IMAGE_WIDTH, w_raw);
			end
			mix = pixel_mix_t'($urandom_range(0, 3));
			// Mostly one or two whole frames; some cut short by the next write
			if ($urandom_range(0, 3) == 0) begin
				count = $urandom_range(1, frame);
			end else if (frame > 64) begin
				count = frame;
			end else begin
				count = frame * $urandom_range(1, 2);
			end
			// The last frame stops at the pixel budget
			if (count > RANDOM_PIXELS - random_pixels) begin
				count = RANDOM_PIXELS - random_pixels;
			end
			split = $urandom_range(0, count);
			repeat (split) send_pixel(draw_pixel(mix));
			if ($urandom_range(0, 3) == 0) begin
				set_register($urandom_range(0, 1) ? REG_UNUSED_3 : REG_UNUSED_2,
					glmf_pkg::CFG_DATA_BITS'($urandom_range(0, 127)));
			end
			repeat (count - split) send_pixel(draw_pixel(mix));
			random_pixels += count;
			phases++;
		end

		settle();
		$display("Run covered %0d pixels and %0d peaks over %0d random frames plus directed grids,",
			sb.pixels, sb.peaks, phases);
		$display("with %0d register writes including clamped, zero and unmapped ones.", sb.writes);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
